### sv/modular_exponentiation_prime_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Shared checks written against clk and arst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_PRIME_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_PRIME_TOP_MACROS_SVH

// antecedent implies consequent, checked outside reset
`define MEXP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never hold outside reset
`define MEXP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Constants shared by the modular exponentiation block and its multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int BASE_W = 63;
	localparam int EXP_W  = 63;
	localparam int RES_W  = 30;

	localparam logic [RES_W-1:0] PRIME_MOD = 30'd1000000007;
	localparam logic [RES_W-1:0] INV_EXP   = 30'd1000000005;

	// conditional subtract of the modulus, input below 2P
	function automatic logic [RES_W:0] mod_fold(input logic [RES_W:0] x);
		logic [RES_W:0] p;
		p = {1'b0, PRIME_MOD};
		mod_fold = (x >= p) ? (x - p) : x;
	endfunction

endpackage

### sv/mexp_mul.sv
// ----------------------------------------------------------------------------
// mexp_mul
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mexp_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mexp_pkg::RES_W-1:0]    a,
	input  logic [mexp_pkg::RES_W-1:0]    b,
	output logic                          done,
	output logic [mexp_pkg::RES_W-1:0]    prod
);

	localparam int CNT_W = $clog2(mexp_pkg::RES_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(mexp_pkg::RES_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [mexp_pkg::RES_W-1:0] a_q;
	logic [mexp_pkg::RES_W-1:0] b_q;
	logic [mexp_pkg::RES_W-1:0] acc_q;
	logic [mexp_pkg::RES_W:0]   dbl;
	logic [mexp_pkg::RES_W:0]   sum;

	// acc = 2*acc + bit*a, kept below P
	always_comb begin
		dbl = mexp_pkg::mod_fold({acc_q, 1'b0});
		sum = mexp_pkg::mod_fold(dbl + (b_q[mexp_pkg::RES_W-1] ?
			{1'b0, a_q} : '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= {b_q[mexp_pkg::RES_W-2:0], 1'b0};
			acc_q <= sum[mexp_pkg::RES_W-1:0];
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

### sv/modular_exponentiation_prime_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_prime_top
// base^exponent or base^(P-2) modulo P = 1000000007, right-to-left
// square-and-multiply on two bit-serial modular multipliers.
// ----------------------------------------------------------------------------
//  channel | handshake           | fields
//  in      | in_valid, in_stall  | action, base, exponent
//  out     | out_valid, out_stall| residue
//
// Base reduction takes one base bit per cycle.
// Each exponent bit up to the highest set one costs a multiplier pass
// plus launch and update; inverse uses a 30-bit exponent.
// One word in flight; in_stall is high from acceptance until the result
// is loaded into the output register. Reset clears all control state.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_prime_top_macros.svh"

module modular_exponentiation_prime_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [mexp_pkg::BASE_W-1:0]   base,
	input  logic [mexp_pkg::EXP_W-1:0]    exponent,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mexp_pkg::RES_W-1:0]    residue
);

	localparam int RED_CNT_W = $clog2(mexp_pkg::BASE_W);
	localparam logic [RED_CNT_W-1:0] RED_LAST = RED_CNT_W'(mexp_pkg::BASE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic [RED_CNT_W-1:0]        red_cnt_q;
	logic [mexp_pkg::BASE_W-1:0] base_sh_q;
	logic [mexp_pkg::EXP_W-1:0]  exp_q;
	logic [mexp_pkg::RES_W-1:0]  acc_q;
	logic [mexp_pkg::RES_W-1:0]  sq_q;
	logic                        out_valid_q;
	logic [mexp_pkg::RES_W-1:0]  residue_q;
	logic [mexp_pkg::RES_W:0]    red_next;
	logic                        mul_start;
	logic                        mul_done;
	logic                        sqr_done;
	logic [mexp_pkg::RES_W-1:0]  mul_prod;
	logic [mexp_pkg::RES_W-1:0]  sqr_prod;

	assign red_next  = mexp_pkg::mod_fold({sq_q, base_sh_q[mexp_pkg::BASE_W-1]});
	assign mul_start = (state_q == ST_STEP) && (exp_q != '0);

	mexp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (acc_q),
		.b      (sq_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	mexp_mul u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sq_q),
		.b      (sq_q),
		.done   (sqr_done),
		.prod   (sqr_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			red_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			residue_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_FINISH))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						red_cnt_q <= '0;
						state_q   <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					red_cnt_q <= red_cnt_q + 1'b1;
					if (red_cnt_q == RED_LAST)
						state_q <= ST_STEP;
				end
				ST_STEP: begin
					state_q <= (exp_q == '0) ? ST_FINISH : ST_WAIT;
				end
				ST_WAIT: begin
					if (sqr_done)
						state_q <= ST_STEP;
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						residue_q   <= acc_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				base_sh_q <= base;
				exp_q     <= action ? mexp_pkg::EXP_W'(mexp_pkg::INV_EXP) : exponent;
				sq_q      <= '0;
				acc_q     <= mexp_pkg::RES_W'(1);
			end
			ST_REDUCE: begin
				base_sh_q <= {base_sh_q[mexp_pkg::BASE_W-2:0], 1'b0};
				sq_q      <= red_next[mexp_pkg::RES_W-1:0];
			end
			ST_WAIT: begin
				if (sqr_done) begin
					if (exp_q[0])
						acc_q <= mul_prod;
					sq_q  <= sqr_prod;
					exp_q <= {1'b0, exp_q[mexp_pkg::EXP_W-1:1]};
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign residue   = residue_q;

	`MEXP_ASSERT_IMPL(a_res_range, out_valid, residue < mexp_pkg::PRIME_MOD,
		"residue not below modulus")
	`MEXP_ASSERT_NEVER(a_mul_sync, mul_done != sqr_done, "multipliers out of step")
	`MEXP_ASSERT_IMPL(a_operands_reduced, (state_q == ST_STEP) || (state_q == ST_WAIT),
		(acc_q < mexp_pkg::PRIME_MOD) && (sq_q < mexp_pkg::PRIME_MOD),
		"operand not reduced")

endmodule
